// File: src/psx_pkg.sv
package psx_pkg;

    // Port pins on the parallel data byte.
    localparam logic [7:0] PIN_CMD = 8'h01;
    localparam logic [7:0] PIN_SEL = 8'h02;
    localparam logic [7:0] PIN_CLK = 8'h04;
    localparam logic [7:0] PIN_PWR = 8'hf8;

    localparam logic [7:0] DRIVE_IDLE = PIN_CLK | PIN_SEL | PIN_PWR;

    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h42;
    localparam logic [7:0] CMD_NONE  = 8'h00;
    localparam logic [7:0] ACK_BYTE  = 8'h5a;
    localparam logic [7:0] LINE_INV  = 8'h80;

    localparam logic [3:0] TYPE_DIGITAL = 4'd4;
    localparam logic [3:0] TYPE_ANALOG  = 4'd7;

    localparam logic [2:0] PAD_SLOT_NONE = 3'd5;

    typedef struct packed {
        logic [3:0] device_type;
        logic       report_valid;
        logic [7:0] buttons;
    } report_t;

    typedef struct packed {
        logic [7:0] port_data;
        logic       busy_res;
        logic       done_res;
        report_t    report;
    } step_res_t;

endpackage

// File: src/psx_pad_poll_sequencer_top.sv
// Channel   Direction  Handshake           Beat contents
// s_        in         s_valid / s_ready   port_status, start_req (one delay tick)
// m_        out        m_valid / m_ready   port_data, busy/done, device_type, report, pad_index
// cfg_      in         cfg_valid/cfg_ready pad_mask write data
//
// Each input beat is one tick of the pad protocol and yields exactly one result beat.
// A beat passes an input register, then the sequencer step, then the result register,
// and one beat per cycle is sustained while m_ready stays high.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// sequencer to idle with pad_mask cleared. A stalled m_ready holds the result register
// and, once the input register is full too, drops s_ready; cfg_ready is always high.
module psx_pad_poll_sequencer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_port_status,
    input  logic       s_start_req,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_port_data,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [3:0] m_device_type,
    output logic       m_report_valid,
    output logic [7:0] m_buttons,
    output logic [2:0] m_pad_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import psx_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_status_reg;
    logic       in_start_reg;
    logic       out_vld_reg;
    step_res_t  out_res_reg;
    logic [2:0] out_slot_reg;
    logic [7:0] mask_reg;
    logic       step_en;
    step_res_t  step_res;
    logic [2:0] slot;

    assign step_en   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || step_en;
    assign cfg_ready = 1'b1;

    // Pad slot of the first enabled mask bit in the priority order 6, 7, 5, 4, 3.
    always_comb begin
        if (mask_reg[6]) begin
            slot = 3'd0;
        end else if (mask_reg[7]) begin
            slot = 3'd1;
        end else if (mask_reg[5]) begin
            slot = 3'd2;
        end else if (mask_reg[4]) begin
            slot = 3'd3;
        end else if (mask_reg[3]) begin
            slot = 3'd4;
        end else begin
            slot = PAD_SLOT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 8'h00;
        end else if (cfg_valid && cfg_ready) begin
            mask_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_status_reg <= s_port_status;
            in_start_reg  <= s_start_req;
        end
    end

    psx_seq_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .port_status (in_status_reg),
        .start_req   (in_start_reg),
        .pad_mask    (mask_reg),
        .res         (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step_en) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_res_reg  <= step_res;
            out_slot_reg <= slot;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_port_data    = out_res_reg.port_data;
    assign m_busy_res     = out_res_reg.busy_res;
    assign m_done_res     = out_res_reg.done_res;
    assign m_device_type  = out_res_reg.report.device_type;
    assign m_report_valid = out_res_reg.report.report_valid;
    assign m_buttons      = out_res_reg.report.buttons;
    assign m_pad_index    = out_slot_reg;

    // The end of a packet always leaves the sequencer idle with select raised.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> (!m_busy_res && (m_port_data == DRIVE_IDLE)))
        else $error("done beat not idle");

    // A report only comes with the end of a packet.
    a_report_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_report_valid) |-> m_done_res)
        else $error("report without done");

    // Buttons are zero unless a report is given.
    a_buttons_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_report_valid) |-> (m_buttons == 8'h00))
        else $error("buttons without report");

    // A stepped beat is always captured in the result register.
    a_step_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_vld_reg)
        else $error("result lost");

endmodule

// File: src/psx_btn_decode.sv
module psx_btn_decode (
    input  logic            done,
    input  logic [7:0]      id_byte,
    input  logic [7:0]      first_data,
    output psx_pkg::report_t report
);
    import psx_pkg::*;

    logic [3:0] dev_type;
    logic       is_valid;
    logic [7:0] pressed;

    // The pad reports buttons active low.
    always_comb begin
        dev_type = id_byte[7:4];
        is_valid = done && ((dev_type == TYPE_DIGITAL) || (dev_type == TYPE_ANALOG));
        pressed  = 8'h00;
        if (is_valid) begin
            pressed[0] = ~first_data[3];
            pressed[1] = ~first_data[0];
            pressed[2] = ~first_data[7];
            pressed[3] = ~first_data[5];
            pressed[4] = ~first_data[6];
            pressed[5] = ~first_data[4];
            if (dev_type == TYPE_ANALOG) begin
                pressed[6] = ~first_data[2];
                pressed[7] = ~first_data[1];
            end
        end
        report.device_type  = done ? dev_type : 4'd0;
        report.report_valid = is_valid;
        report.buttons      = pressed;
    end

endmodule

// File: src/psx_seq_core.sv
module psx_seq_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          port_status,
    input  logic                start_req,
    input  logic [7:0]          pad_mask,
    output psx_pkg::step_res_t  res
);
    import psx_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_SELECT   = 5'b00010,
        PH_DESELECT = 5'b00100,
        PH_HEADER   = 5'b01000,
        PH_DATA     = 5'b10000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [4:0] byte_cnt_reg, byte_cnt_next;
    logic       half_reg, half_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] first_reg, first_next;

    logic [7:0] drive;
    logic       done;
    logic [7:0] cmd_byte;
    logic       cmd_bit;
    logic [5:0] len2;
    logic [4:0] byte_inc;

    // Command bit for the next low-clock tick, taken from the updated counters.
    always_comb begin
        cmd_byte = CMD_NONE;
        if (phase_next == PH_HEADER) begin
            if (byte_cnt_next == 5'd0) begin
                cmd_byte = CMD_START;
            end else if (byte_cnt_next == 5'd1) begin
                cmd_byte = CMD_POLL;
            end
        end
        cmd_bit = cmd_byte[bit_cnt_next];
    end

    assign len2     = {1'b0, id_reg[3:0], 1'b0};
    assign byte_inc = byte_cnt_reg + 5'd1;

    always_comb begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        half_next     = half_reg;
        shift_next    = shift_reg;
        id_next       = id_reg;
        first_next    = first_reg;
        drive         = DRIVE_IDLE;
        done          = 1'b0;

        case (phase_reg)
            PH_IDLE: begin
                if (start_req && (pad_mask != 8'h00)) begin
                    phase_next    = PH_SELECT;
                    bit_cnt_next  = 3'd0;
                    byte_cnt_next = 5'd0;
                    half_next     = 1'b0;
                    shift_next    = 8'h00;
                    id_next       = 8'h00;
                    first_next    = 8'hff;
                end
            end
            PH_SELECT: begin
                drive      = PIN_CLK | PIN_PWR;
                phase_next = PH_DESELECT;
            end
            PH_DESELECT: begin
                phase_next    = PH_HEADER;
                bit_cnt_next  = 3'd0;
                byte_cnt_next = 5'd0;
                half_next     = 1'b0;
                shift_next    = 8'h00;
                drive         = (cmd_bit ? PIN_CMD : 8'h00) | PIN_PWR;
            end
            PH_HEADER, PH_DATA: begin
                if (!half_reg) begin
                    if (((port_status ^ LINE_INV) & pad_mask) != 8'h00) begin
                        shift_next[bit_cnt_reg] = 1'b1;
                    end
                    half_next = 1'b1;
                    drive     = (cmd_bit ? PIN_CMD : 8'h00) | PIN_PWR | PIN_CLK;
                end else begin
                    half_next = 1'b0;
                    if (bit_cnt_reg != 3'd7) begin
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                    end else begin
                        shift_next   = 8'h00;
                        bit_cnt_next = 3'd0;
                        // A whole byte has been clocked in.
                        if (phase_reg == PH_HEADER) begin
                            if (byte_cnt_reg == 5'd0) begin
                                byte_cnt_next = 5'd1;
                            end else if (byte_cnt_reg == 5'd1) begin
                                id_next       = shift_reg;
                                byte_cnt_next = 5'd2;
                            end else if (shift_reg != ACK_BYTE) begin
                                id_next = 8'h00;
                                done    = 1'b1;
                            end else if (len2 == 6'd0) begin
                                done = 1'b1;
                            end else begin
                                phase_next    = PH_DATA;
                                byte_cnt_next = 5'd0;
                            end
                        end else begin
                            if (byte_cnt_reg == 5'd0) begin
                                first_next = shift_reg;
                            end
                            byte_cnt_next = byte_inc;
                            done = ({1'b0, byte_inc} >= len2);
                        end
                        if (done) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    if (!done) begin
                        drive = (cmd_bit ? PIN_CMD : 8'h00) | PIN_PWR;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= 3'd0;
            byte_cnt_reg <= 5'd0;
            half_reg     <= 1'b0;
            shift_reg    <= 8'h00;
            id_reg       <= 8'h00;
            first_reg    <= 8'hff;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            half_reg     <= half_next;
            shift_reg    <= shift_next;
            id_reg       <= id_next;
            first_reg    <= first_next;
        end
    end

    psx_btn_decode u_decode (
        .done       (done),
        .id_byte    (id_next),
        .first_data (first_next),
        .report     (res.report)
    );

    assign res.port_data = drive;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.done_res  = done;

endmodule

// File: tb/tb_psx_pad_poll_sequencer_top.sv
`timescale 1ns / 1ps

module tb_psx_pad_poll_sequencer_top;
    import psx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENT_TICKS = 48;

    typedef enum logic [4:0] {
        SEQ_IDLE     = 5'b00001,
        SEQ_SELECT   = 5'b00010,
        SEQ_DESELECT = 5'b00100,
        SEQ_HEADER   = 5'b01000,
        SEQ_DATA     = 5'b10000
    } seq_phase_t;

    typedef struct packed {
        step_res_t  res;
        logic [2:0] pad_index;
    } tick_result_t;

    class pad_poll_scoreboard;
        logic [7:0]   pad_mask;
        seq_phase_t   phase;
        logic [2:0]   bit_idx;
        logic [4:0]   byte_idx;
        logic         clk_high;
        logic [7:0]   shift_reg;
        logic [7:0]   id_byte;
        logic [7:0]   first_byte;
        tick_result_t expected_ticks[$];
        int           errors;

        function new();
            pad_mask   = 8'h00;
            phase      = SEQ_IDLE;
            bit_idx    = 3'd0;
            byte_idx   = 5'd0;
            clk_high   = 1'b0;
            shift_reg  = 8'h00;
            id_byte    = 8'h00;
            first_byte = 8'hff;
            errors     = 0;
        endfunction

        function void set_mask(logic [7:0] value);
            pad_mask = value;
        endfunction

        function bit is_idle();
            return phase == SEQ_IDLE;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // Data pins for the low-clock half of the current command bit.
        function logic [7:0] low_drive();
            logic [7:0] cmd;
            cmd = CMD_NONE;
            if (phase == SEQ_HEADER && byte_idx == 5'd0) cmd = CMD_START;
            else if (phase == SEQ_HEADER && byte_idx == 5'd1) cmd = CMD_POLL;
            return (cmd[bit_idx] ? PIN_CMD : 8'h00) | PIN_PWR;
        endfunction

        function void note_tick(logic [7:0] status, logic start);
            tick_result_t r;
            logic [7:0]   b;
            logic [7:0]   d;
            logic [4:0]   len2;
            logic         done;
            logic         analog;
            r = '0;
            r.res.port_data = DRIVE_IDLE;
            done = 1'b0;
            case (phase)
                SEQ_IDLE: begin
                    if (start && pad_mask != 8'h00) begin
                        phase      = SEQ_SELECT;
                        bit_idx    = 3'd0;
                        byte_idx   = 5'd0;
                        clk_high   = 1'b0;
                        shift_reg  = 8'h00;
                        id_byte    = 8'h00;
                        first_byte = 8'hff;
                    end
                end
                SEQ_SELECT: begin
                    r.res.port_data = PIN_CLK | PIN_PWR;
                    phase = SEQ_DESELECT;
                end
                SEQ_DESELECT: begin
                    phase     = SEQ_HEADER;
                    bit_idx   = 3'd0;
                    byte_idx  = 5'd0;
                    clk_high  = 1'b0;
                    shift_reg = 8'h00;
                    r.res.port_data = low_drive();
                end
                default: begin
                    if (!clk_high) begin
                        if (((status ^ LINE_INV) & pad_mask) != 8'h00) shift_reg[bit_idx] = 1'b1;
                        r.res.port_data = low_drive() | PIN_CLK;
                        clk_high = 1'b1;
                    end else begin
                        clk_high = 1'b0;
                        if (bit_idx != 3'd7) begin
                            bit_idx = bit_idx + 3'd1;
                            r.res.port_data = low_drive();
                        end else begin
                            b = shift_reg;
                            shift_reg = 8'h00;
                            bit_idx = 3'd0;
                            len2 = {id_byte[3:0], 1'b0};
                            if (phase == SEQ_HEADER) begin
                                if (byte_idx == 5'd0) begin
                                    byte_idx = 5'd1;
                                end else if (byte_idx == 5'd1) begin
                                    id_byte = b;
                                    byte_idx = 5'd2;
                                end else if (b != ACK_BYTE) begin
                                    id_byte = 8'h00;
                                    done = 1'b1;
                                end else if (len2 == 5'd0) begin
                                    done = 1'b1;
                                end else begin
                                    phase = SEQ_DATA;
                                    byte_idx = 5'd0;
                                end
                            end else begin
                                if (byte_idx == 5'd0) first_byte = b;
                                byte_idx = byte_idx + 5'd1;
                                done = (byte_idx >= len2);
                            end
                            if (done) phase = SEQ_IDLE;
                            else r.res.port_data = low_drive();
                        end
                    end
                end
            endcase

            if (done) begin
                d = first_byte;
                r.res.done_res = 1'b1;
                r.res.report.device_type = id_byte[7:4];
                r.res.report.report_valid = (id_byte[7:4] == TYPE_DIGITAL) ||
                                            (id_byte[7:4] == TYPE_ANALOG);
                analog = (id_byte[7:4] == TYPE_ANALOG);
                // The pad reports active low; the thumb bits only exist on analog pads.
                if (r.res.report.report_valid)
                    r.res.report.buttons = {analog & ~d[1], analog & ~d[2], ~d[4], ~d[6],
                                            ~d[5], ~d[7], ~d[0], ~d[3]};
            end
            r.res.busy_res = (phase != SEQ_IDLE);
            if (pad_mask[6]) r.pad_index = 3'd0;
            else if (pad_mask[7]) r.pad_index = 3'd1;
            else if (pad_mask[5]) r.pad_index = 3'd2;
            else if (pad_mask[4]) r.pad_index = 3'd3;
            else if (pad_mask[3]) r.pad_index = 3'd4;
            else r.pad_index = PAD_SLOT_NONE;
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0) begin
                $error("result beat arrived with no tick outstanding");
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("port_data", want.res.port_data, got.res.port_data);
            compare_field("busy_res", want.res.busy_res, got.res.busy_res);
            compare_field("done_res", want.res.done_res, got.res.done_res);
            compare_field("device_type", want.res.report.device_type,
                          got.res.report.device_type);
            compare_field("report_valid", want.res.report.report_valid,
                          got.res.report.report_valid);
            compare_field("buttons", want.res.report.buttons, got.res.report.buttons);
            compare_field("pad_index", want.pad_index, got.pad_index);
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_port_status;
    logic       s_start_req;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_port_data;
    logic       m_busy_res;
    logic       m_done_res;
    logic [3:0] m_device_type;
    logic       m_report_valid;
    logic [7:0] m_buttons;
    logic [2:0] m_pad_index;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    pad_poll_scoreboard board = new();
    int src_idle_pct;
    int dst_idle_pct;
    int ticks_sent;
    int cycle_count;

    psx_pad_poll_sequencer_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_port_status  (s_port_status),
        .s_start_req    (s_start_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_port_data    (m_port_data),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_device_type  (m_device_type),
        .m_report_valid (m_report_valid),
        .m_buttons      (m_buttons),
        .m_pad_index    (m_pad_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_monitor
        tick_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.res.port_data           = m_port_data;
            got.res.busy_res            = m_busy_res;
            got.res.done_res            = m_done_res;
            got.res.report.device_type  = m_device_type;
            got.res.report.report_valid = m_report_valid;
            got.res.report.buttons      = m_buttons;
            got.pad_index               = m_pad_index;
            board.check_result(got);
        end
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic send_tick(input logic [7:0] status, input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_port_status <= status;
        s_start_req   <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_tick(status, start);
        ticks_sent++;
    endtask

    // Holds the sender off until every result is back, then writes the mask.
    task automatic drain_and_configure(input logic [7:0] mask);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_mask(mask);
        cfg_valid <= 1'b0;
    endtask

    // Status byte whose masked, inverted data line reads as the wanted bit.
    function automatic logic [7:0] line_status(input logic value, input logic [7:0] mask);
        logic [7:0] x;
        int j;
        x = 8'($urandom);
        if (value) begin
            do j = $urandom_range(7); while (!mask[j]);
            x[j] = 1'b1;
        end else begin
            x = x & ~mask;
        end
        return x ^ LINE_INV;
    endfunction

    task automatic run_poll();
        logic [7:0] pad_bytes[$];
        logic [3:0] dev_type;
        logic [3:0] pkt_len;
        logic [7:0] ack;
        int pick;
        // A mask change may have left a poll running; finish it with noise.
        while (!board.is_idle()) send_tick(8'($urandom), 1'($urandom_range(1)));
        pick = $urandom_range(9);
        dev_type = (pick < 4) ? TYPE_DIGITAL : (pick < 8) ? TYPE_ANALOG : 4'($urandom);
        pick = $urandom_range(19);
        pkt_len = 4'((pick < 14) ? $urandom_range(2) :
                     (pick < 19) ? $urandom_range(5, 3) : $urandom_range(15));
        ack = ($urandom_range(9) == 0) ? 8'($urandom) : ACK_BYTE;
        pad_bytes.push_back(8'($urandom));
        pad_bytes.push_back({dev_type, pkt_len});
        pad_bytes.push_back(ack);
        if (ack == ACK_BYTE) repeat (2 * pkt_len) pad_bytes.push_back(8'($urandom));
        send_tick(8'($urandom), 1'b1);
        send_tick(8'($urandom), 1'($urandom_range(1)));
        send_tick(8'($urandom), 1'($urandom_range(1)));
        foreach (pad_bytes[i]) begin
            for (int k = 0; k < 8; k++) begin
                send_tick(line_status(pad_bytes[i][k], board.pad_mask),
                          1'($urandom_range(1)));
                send_tick(8'($urandom), 1'($urandom_range(1)));
            end
        end
        // Now and then a few idle ticks, which may also kick off a noise poll.
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3)) send_tick(8'($urandom), 1'($urandom_range(1)));
    endtask

    initial begin
        logic [7:0] seg_masks[9];
        int seg_end;
        seg_masks = '{8'hff, 8'h07, 8'h40, 8'h80, 8'h20, 8'h00, 8'h10, 8'h08, 8'h00};
        seg_masks[5] = 8'($urandom_range(255, 1));
        seg_masks[8] = 8'($urandom_range(255, 1));
        ticks_sent  = 0;
        src_idle_pct = 19;
        dst_idle_pct = 83;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_port_status <= 8'h00;
        s_start_req   <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 8'h00;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Starts are ignored while the mask is empty.
        drain_and_configure(8'h00);
        send_tick(8'h00, 1'b1);
        send_tick(8'hff, 1'b1);
        drain_and_configure(8'hff);
        // Poll start, then starts raised while busy with the line at both levels.
        send_tick(8'hff, 1'b1);
        send_tick(8'h00, 1'b1);
        send_tick(8'hff, 1'b1);
        for (int k = 0; k < 16; k++)
            send_tick((k % 3 == 0) ? LINE_INV : ((k % 3 == 1) ? 8'hff : 8'h7f), 1'b1);

        for (int seg = 0; seg < 9; seg++) begin
            if (seg < 3) begin
                src_idle_pct = 19;
                dst_idle_pct = 83;
            end else if (seg < 6) begin
                src_idle_pct = 83;
                dst_idle_pct = 19;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            drain_and_configure(seg_masks[seg]);
            seg_end = ticks_sent + SEGMENT_TICKS;
            while (ticks_sent < seg_end) run_poll();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
